/* design/rsf_pkg.sv */
// shared types and constants for the rgb sharpen filter
`timescale 1ns / 1ps

package rsf_pkg;

    // one rgb pixel, red in the top byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one pixel leaving the line stores, with its window centre position
    typedef struct packed {
        logic       valid;
        logic       emit;
        logic [10:0] column;
        logic [11:0] row;
        pixel_t     up;
        pixel_t     mid;
        pixel_t     pix;
    } win_in_t;

    // one filtered result beat
    typedef struct packed {
        pixel_t     pix;
        logic [10:0] column;
        logic [11:0] row;
    } result_t;

    // output queue sizing, power of two
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // register reset values and smallest usable frame side
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam int          MIN_DIM      = 3;

endpackage

/* design/rgb_sharpen_3x3_filter.sv */
// top level of the 3x3 rgb sharpening filter
`timescale 1ns / 1ps

// Takes a raster-order stream of rgb pixels, one beat per pixel, on the input
// channel (in_valid / in_stall); frame_start puts the beat at column 0, row 0.
// Each pixel whose 3x3 neighborhood lies inside the frame gives one result beat
// on the output channel (out_valid / out_stall): the sharpened pixel (centre
// weight 9, neighbors -1, clamped to 0..255) with its column and row. Border
// pixels give no beat. image_width and image_height are set through the
// cfg_write port while the block is idle; values below 3 act as 3 and values
// above the line store size act as that size.
// Throughput is one pixel per clock while in_stall is low. A result beat is
// registered in the line memory read stage, then in the window and kernel stage,
// then written into the result queue before it shows on out_valid.
// A four-beat result queue at the output lets input beats keep flowing while
// a result waits; in_stall rises only when four results are owed and none has
// been taken. Reset empties the pipeline and queue, sets the frame to 640 by
// 480 and the position to column 0, row 0; line memory contents are not
// cleared and need none.
module rgb_sharpen_3x3_filter
    import rsf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_start,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [10:0] out_column,
    output logic [11:0] out_row
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (WW > 12) ? WW : 12;
    localparam int HCMP = (HW > 13) ? HW : 13;

    logic [11:0]          image_width_reg;
    logic [12:0]          image_height_reg;
    logic [CW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;
    logic [CW-1:0]        col_next;
    logic [RW-1:0]        row_next;
    logic [OUT_CNT_W-1:0] pend_reg;
    logic [OUT_CNT_W-1:0] pend_next;
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic [10:0]          s1_column_reg;
    logic [11:0]          s1_row_reg;

    logic [WCMP-1:0] width_ext;
    logic [HCMP-1:0] height_ext;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [CW-1:0]   col_a;
    logic [RW-1:0]   row_a;
    logic            wrap_a;
    logic [RW:0]     row_b;
    logic [CW-1:0]   col_cur;
    logic [RW-1:0]   row_cur;
    logic [CW:0]     col_inc;
    logic [RW:0]     row_inc;
    logic            emit_cur;
    logic            accept;
    logic            pop;
    pixel_t          pix_in;
    pixel_t          up_data;
    pixel_t          mid_data;
    pixel_t          pix_data;
    win_in_t         win_in;
    logic            res_valid;
    result_t         res;
    result_t         head_data;

    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign in_stall = (pend_reg == OUT_CNT_W'(OUT_DEPTH));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[11:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp the frame size between the smallest usable side and what the line stores hold
    always_comb
    begin
        width_ext  = WCMP'(image_width_reg);
        height_ext = HCMP'(image_height_reg);
        if (width_ext < WCMP'(MIN_DIM))
        begin
            w_eff = WW'(MIN_DIM);
        end
        else if (width_ext > WCMP'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        if (height_ext < HCMP'(MIN_DIM))
        begin
            h_eff = HW'(MIN_DIM);
        end
        else if (height_ext > HCMP'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_ext);
        end
    end

    // position of this beat and of the next one
    always_comb
    begin
        col_a   = frame_start ? '0 : col_reg;
        row_a   = frame_start ? '0 : row_reg;
        wrap_a  = (WW'(col_a) >= w_eff);
        row_b   = (RW+1)'(row_a) + (RW+1)'(wrap_a);
        col_cur = wrap_a ? '0 : col_a;
        row_cur = (row_b >= (RW+1)'(h_eff)) ? '0 : RW'(row_b);
        col_inc = (CW+1)'(col_cur) + (CW+1)'(1);
        row_inc = (RW+1)'(row_cur) + (RW+1)'(1);
        col_next = CW'(col_inc);
        row_next = row_cur;
        if (col_inc >= (CW+1)'(w_eff))
        begin
            col_next = '0;
            row_next = (row_inc >= (RW+1)'(h_eff)) ? '0 : RW'(row_inc);
        end
        emit_cur = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
    end

    // position counters and owed-result count
    always_comb
    begin
        pend_next = pend_reg;
        if (accept && emit_cur && !pop)
        begin
            pend_next = pend_reg + OUT_CNT_W'(1);
        end
        else if (pop && !(accept && emit_cur))
        begin
            pend_next = pend_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            pend_reg     <= pend_next;
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit_cur;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // centre position travels alongside the memory read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_column_reg <= 11'(col_cur - CW'(1));
            s1_row_reg    <= 12'(row_cur - RW'(1));
        end
    end

    assign pix_in = '{red: red_in, green: green_in, blue: blue_in};

    rsf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (col_cur),
        .pix_in   (pix_in),
        .up_data  (up_data),
        .mid_data (mid_data),
        .pix_data (pix_data)
    );

    assign win_in = '{valid:  s1_valid_reg,
                      emit:   s1_emit_reg,
                      column: s1_column_reg,
                      row:    s1_row_reg,
                      up:     up_data,
                      mid:    mid_data,
                      pix:    pix_data};

    rsf_window_filter u_window_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_in    (win_in),
        .res_valid (res_valid),
        .res       (res)
    );

    rsf_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .head_valid (out_valid),
        .head_data  (head_data)
    );

    assign red_out    = head_data.pix.red;
    assign green_out  = head_data.pix.green;
    assign blue_out   = head_data.pix.blue;
    assign out_column = head_data.column;
    assign out_row    = head_data.row;

endmodule

/* design/rsf_line_store.sv */
// two line memories with read-modify-write and same-address forwarding
`timescale 1ns / 1ps

module rsf_line_store
    import rsf_pkg::*;
#(
    parameter int DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  pixel_t                   pix_in,
    output pixel_t                   up_data,
    output pixel_t                   mid_data,
    output pixel_t                   pix_data
);

    localparam int AW = $clog2(DEPTH);

    pixel_t upper_mem [DEPTH];
    pixel_t middle_mem [DEPTH];

    logic          s1_valid_reg;
    logic          fwd_hit_reg;
    logic [AW-1:0] s1_addr_reg;
    pixel_t        s1_pix_reg;
    pixel_t        fwd_up_reg;
    pixel_t        fwd_mid_reg;
    pixel_t        up_rd_reg;
    pixel_t        mid_rd_reg;
    logic          fwd_hit_next;

    // a read at the address being written this cycle sees stale data
    assign fwd_hit_next = s1_valid_reg && (s1_addr_reg == rd_addr);

    assign up_data  = fwd_hit_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_data = fwd_hit_reg ? fwd_mid_reg : mid_rd_reg;
    assign pix_data = s1_pix_reg;

    // upper line: takes the old middle row entry
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg] <= mid_data;
        end
        if (rd_en)
        begin
            up_rd_reg <= upper_mem[rd_addr];
        end
    end

    // middle line: takes the incoming pixel
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
        if (rd_en)
        begin
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            if (rd_en)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // stage payload and forwarded write data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= pix_in;
            fwd_up_reg  <= mid_data;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

endmodule

/* design/rsf_window_filter.sv */
// 3x3 window registers and the sharpening kernel
`timescale 1ns / 1ps

module rsf_window_filter
    import rsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  win_in_t win_in,
    output logic    res_valid,
    output result_t res
);

    pixel_t      win_reg [9];
    logic        s2_valid_reg;
    logic        s2_emit_reg;
    logic [10:0] s2_column_reg;
    logic [11:0] s2_row_reg;
    logic [8:0][7:0] red_taps;
    logic [8:0][7:0] green_taps;
    logic [8:0][7:0] blue_taps;

    // centre times nine minus the ring of eight, clamped to a byte
    function automatic logic [7:0] sharpen_ch(input logic [8:0][7:0] taps);
        logic [11:0]        centre9;
        logic [10:0]        ring;
        logic signed [12:0] sum;
        centre9 = 12'({taps[4], 3'b000}) + 12'(taps[4]);
        ring = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4)
            begin
                ring = ring + 11'(taps[k]);
            end
        end
        sum = $signed({1'b0, centre9}) - $signed({2'b00, ring});
        if (sum < 0)
        begin
            return 8'd0;
        end
        else if (sum > 13'sd255)
        begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

    // shift the window one column per pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (win_in.valid)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_in.up;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= win_in.mid;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= win_in.pix;
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= win_in.valid;
            s2_emit_reg  <= win_in.emit;
        end
    end

    // centre position
    always_ff @(posedge clk)
    begin
        if (win_in.valid)
        begin
            s2_column_reg <= win_in.column;
            s2_row_reg    <= win_in.row;
        end
    end

    // split channels
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            red_taps[k]   = win_reg[k].red;
            green_taps[k] = win_reg[k].green;
            blue_taps[k]  = win_reg[k].blue;
        end
    end

    assign res_valid     = s2_valid_reg && s2_emit_reg;
    assign res.pix.red   = sharpen_ch(red_taps);
    assign res.pix.green = sharpen_ch(green_taps);
    assign res.pix.blue  = sharpen_ch(blue_taps);
    assign res.column    = s2_column_reg;
    assign res.row       = s2_row_reg;

endmodule

/* design/rsf_out_fifo.sv */
// small result queue that decouples the output stall from the pipeline
`timescale 1ns / 1ps

module rsf_out_fifo
    import rsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output result_t head_data
);

    result_t                fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   head_reg;
    logic [OUT_PTR_W-1:0]   tail_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;

    assign head_valid = (count_reg != '0);
    assign head_data  = fifo_mem[head_reg];

    // occupancy, the upstream credit count keeps it from overflowing
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= tail_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + OUT_PTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= push_data;
        end
    end

endmodule

/* design/rsf_checker.sv */
// port-level checks for the rgb sharpen filter and their binding
`timescale 1ns / 1ps

module rsf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out,
    input logic [10:0] out_column,
    input logic [11:0] out_row
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(out_column) && $stable(out_row))
        else $error("result payload changed while stalled");

    // reset leaves nothing pending and the input open
    assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
        else $error("channels not idle in reset");

    // input backpressure only while results wait in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result offered");

endmodule

bind rgb_sharpen_3x3_filter rsf_checker u_rsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .out_column (out_column),
    .out_row    (out_row)
);

/* test/tb.sv */
// testbench for the rgb sharpen filter: directed and random frames checked against a local predictor
`timescale 1ns / 1ps

module tb
    import rsf_pkg::*;
();

    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 4096;
    localparam int SETTLE       = 6;
    localparam int BUSY_PCT     = 18;
    localparam int RANDOM_ITEMS = 80;

    // pixel content patterns
    localparam int PIX_UNIFORM   = 0;
    localparam int PIX_BAND      = 1;
    localparam int PIX_SATURATED = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        frame_start;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] out_column;
    logic [11:0] out_row;

    // predictor state: registers, line stores, window and raster position
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    pixel_t      upper_px [MAX_W];
    pixel_t      middle_px [MAX_W];
    pixel_t      win [9];
    int unsigned col_pos;
    int unsigned row_pos;

    // sharpened pixels owed by the block, oldest first
    result_t     sharpened_q [$];

    int          idle_pct = BUSY_PCT;
    int          items_sent = 0;
    int          frames_sent = 0;
    int          results_seen = 0;
    int          err_count = 0;

    rgb_sharpen_3x3_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (frame_start),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .out_column  (out_column),
        .out_row     (out_row)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("run limit reached with %0d results still owed", sharpened_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // random receiver stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // frame side as the block uses it
    function automatic int unsigned clamp_side(input int unsigned v, input int unsigned top);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > top)
            return top;
        return v;
    endfunction

    // 9 times the centre minus the eight neighbors, clamped to a byte
    function automatic logic [7:0] sharpen_channel(input int shift);
        int          sum;
        logic [23:0] word;
        sum = 0;
        for (int k = 0; k < 9; k++)
        begin
            word = win[k] >> shift;
            sum += (k == 4) ? 9 * int'(word[7:0]) : -int'(word[7:0]);
        end
        if (sum < 0)
            return 8'd0;
        if (sum > 255)
            return 8'd255;
        return sum[7:0];
    endfunction

    // place one pixel in the raster, shift the window, queue the result if interior
    function automatic void sharpen_step(input logic first, input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t      up;
        pixel_t      mid;
        result_t     res;
        w = clamp_side(width_reg, MAX_W);
        h = clamp_side(height_reg, MAX_H);
        if (first)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        up = upper_px[c];
        mid = middle_px[c];
        win[0] = win[1]; win[1] = win[2]; win[2] = up;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;
        upper_px[c] = mid;
        middle_px[c] = px;
        if (c >= 2 && r >= 2)
        begin
            res.pix.red = sharpen_channel(16);
            res.pix.green = sharpen_channel(8);
            res.pix.blue = sharpen_channel(0);
            res.column = 11'(c - 1);
            res.row = 12'(r - 1);
            sharpened_q.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    // pixel content: uniform, narrow band, or saturated channels
    function automatic pixel_t random_pixel(input int mode);
        logic [7:0] ch [3];
        for (int i = 0; i < 3; i++)
        begin
            case (mode)
                PIX_BAND: ch[i] = 8'($urandom_range(140, 100));
                PIX_SATURATED: ch[i] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                default: ch[i] = 8'($urandom_range(255));
            endcase
        end
        return {ch[0], ch[1], ch[2]};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
    endtask

    // one input beat, with a random gap before it
    task automatic send_pixel(input logic first, input pixel_t px);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frame_start <= first;
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sharpen_step(first, px);
        items_sent++;
    endtask

    task automatic send_run(input int count, input logic with_start, input int mode);
        for (int k = 0; k < count; k++)
            send_pixel(with_start && k == 0, random_pixel(mode));
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic idx, input logic [12:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[11:0];
        else
            height_reg = val;
    endtask

    // stop sending and wait until every owed result has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sharpened_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // compare each result beat with the oldest owed one
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sharpened_q.size() == 0)
                report_mismatch("beat with nothing owed, column", out_column, -1);
            else
            begin
                want = sharpened_q.pop_front();
                if (red_out !== want.pix.red)
                    report_mismatch("red", red_out, want.pix.red);
                if (green_out !== want.pix.green)
                    report_mismatch("green", green_out, want.pix.green);
                if (blue_out !== want.pix.blue)
                    report_mismatch("blue", blue_out, want.pix.blue);
                if (out_column !== want.column)
                    report_mismatch("column", out_column, want.column);
                if (out_row !== want.row)
                    report_mismatch("row", out_row, want.row);
                results_seen++;
            end
        end
    end

    // reset geometry 640x480 and reset position, no frame_start on the first beat,
    // sent with no idling on either side
    task automatic test_reset_geometry();
        idle_pct = 0;
        send_run(2 * 640 + 12, 1'b0, PIX_UNIFORM);
        idle_pct = BUSY_PCT;
        frames_sent++;
    endtask

    // saturation both ways, exact 255, all zero, and the wrap at frame end
    task automatic test_clamp_extremes();
        pixel_t px;
        int     c;
        int     r;
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        for (int f = 0; f < 2; f++)
        begin
            for (int k = 0; k < 12; k++)
            begin
                c = k % 3;
                r = k / 3;
                px.red = (c == 1 && r == 1) ? 8'd255 : 8'd0;
                px.green = 8'd255;
                px.blue = (c == 1 && r == 1) ? 8'd40 : ((c == 1 && r == 2) ? 8'd30 : 8'd20);
                if (f == 1)
                    px = ~px;
                // second frame leans on the wrap, not on frame_start
                send_pixel(f == 0 && k == 0, px);
            end
            frames_sent++;
        end
    endtask

    // out-of-range register values and the width field's unused top bit
    task automatic test_register_limits();
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'h1005);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        send_run(15, 1'b1, PIX_UNIFORM);
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        send_run(9, 1'b1, PIX_SATURATED);
        frames_sent += 2;
    endtask

    // width, then height, lowered below the current position mid-frame
    task automatic test_shrink_mid_frame();
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'd8);
        write_reg(REG_IMAGE_HEIGHT, 13'd6);
        send_run(3 * 8 + 6, 1'b1, PIX_UNIFORM);
        drain();
        write_reg(REG_IMAGE_WIDTH, 13'd4);
        send_run(4, 1'b0, PIX_UNIFORM);
        drain();
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        send_run(16, 1'b0, PIX_BAND);
        frames_sent += 2;
    endtask

    // random small frames, some cut short and restarted, some wrapping on their own
    task automatic test_random_frames();
        int   start_count;
        int   w;
        int   h;
        int   n;
        int   reps;
        logic whole_last;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(10, 3);
            h = $urandom_range(6, 3);
            drain();
            write_reg(REG_IMAGE_WIDTH, 13'(w));
            write_reg(REG_IMAGE_HEIGHT, 13'(h));
            whole_last = 1'b0;
            reps = $urandom_range(2, 1);
            for (int f = 0; f < reps; f++)
            begin
                n = w * h;
                if ($urandom_range(7) == 0)
                    n = $urandom_range(n - 1, 1);
                send_run(n, !(whole_last && $urandom_range(2) == 0),
                         $urandom_range(PIX_SATURATED));
                whole_last = (n == w * h);
                frames_sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        frame_start = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_px[i] = '0;
            middle_px[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_geometry();
        test_clamp_extremes();
        test_register_limits();
        test_shrink_mid_frame();
        test_random_frames();
        drain();

        $display("sent %0d pixels over %0d frames, checked %0d sharpened results",
                 items_sent, frames_sent, results_seen);
        $display("reset frame size, clamped and masked sizes, mid-frame resizes and restarts");
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
